// ===== hdl/afc_pkg.sv =====
package afc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int PLANE_W     = 64;
  localparam int NORMAL_W    = 16;
  localparam int DIST_W      = 16;
  localparam int DIST_LSB    = 48;
  localparam int TAG_W       = 16;
  localparam int AXES        = 3;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    PLANE_LEFT   = 3'd0,
    PLANE_RIGHT  = 3'd1,
    PLANE_TOP    = 3'd2,
    PLANE_BOTTOM = 3'd3,
    PLANE_NEAR   = 3'd4,
    PLANE_FAR    = 3'd5
  } plane_idx_t;

  typedef struct packed {
    logic valid;
    logic in_view;
  } ctl_t;

endpackage

// ===== hdl/afc_cell.sv =====
module afc_cell
  import afc_pkg::*;
#(
  parameter int         COORD_WIDTH      = 16,
  parameter int         NORMAL_FRAC_BITS = 14,
  parameter plane_idx_t PLANE_IDX        = PLANE_LEFT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [PLANE_W-1:0]            cfg_wdata,
  input  ctl_t                          ctl_in,
  input  logic [TAG_W-1:0]              tag_in,
  input  logic signed [COORD_WIDTH-1:0] bmin_in [AXES],
  input  logic signed [COORD_WIDTH-1:0] bmax_in [AXES],
  output ctl_t                          ctl_out,
  output logic [TAG_W-1:0]              tag_out,
  output logic signed [COORD_WIDTH-1:0] bmin_out [AXES],
  output logic signed [COORD_WIDTH-1:0] bmax_out [AXES]
);

  localparam int PROD_W = NORMAL_W + COORD_WIDTH;
  localparam int DSH_W  = DIST_W + NORMAL_FRAC_BITS;
  localparam int ACC_W  = ((PROD_W > DSH_W) ? PROD_W : DSH_W) + 2;

  logic [PLANE_W-1:0] plane_r;

  // stage 1: corner select and products
  ctl_t                          s1_ctl_r;
  logic [TAG_W-1:0]              s1_tag_r;
  logic signed [COORD_WIDTH-1:0] s1_bmin_r [AXES];
  logic signed [COORD_WIDTH-1:0] s1_bmax_r [AXES];
  logic signed [PROD_W-1:0]      s1_prod_r [AXES];
  logic signed [PROD_W-1:0]      s1_prod_nxt [AXES];
  logic signed [DIST_W-1:0]      s1_dist_r;

  // stage 2: sum and plane test
  ctl_t                          ctl_r;
  ctl_t                          ctl_nxt;
  logic [TAG_W-1:0]              tag_r;
  logic signed [COORD_WIDTH-1:0] bmin_r [AXES];
  logic signed [COORD_WIDTH-1:0] bmax_r [AXES];
  logic signed [ACC_W-1:0]       acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (cfg_we && (cfg_index == PLANE_IDX)) begin
      plane_r <= cfg_wdata;
    end
  end

  always_comb begin
    logic signed [NORMAL_W-1:0]    n;
    logic signed [COORD_WIDTH-1:0] c;
    for (int a = 0; a < AXES; a++) begin
      n = plane_r[NORMAL_W*a +: NORMAL_W];
      c = (!n[NORMAL_W-1] && (n != '0)) ? bmin_in[a] : bmax_in[a];
      s1_prod_nxt[a] = n * c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r  <= tag_in;
    s1_bmin_r <= bmin_in;
    s1_bmax_r <= bmax_in;
    s1_prod_r <= s1_prod_nxt;
    s1_dist_r <= plane_r[DIST_LSB +: DIST_W];
  end

  always_comb begin
    acc = ACC_W'(s1_prod_r[0]) + ACC_W'(s1_prod_r[1]) + ACC_W'(s1_prod_r[2])
        + (ACC_W'(s1_dist_r) <<< NORMAL_FRAC_BITS);
    ctl_nxt.valid   = s1_ctl_r.valid;
    ctl_nxt.in_view = s1_ctl_r.in_view && !(!acc[ACC_W-1] && (acc != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= s1_tag_r;
    bmin_r <= s1_bmin_r;
    bmax_r <= s1_bmax_r;
  end

  assign ctl_out  = ctl_r;
  assign tag_out  = tag_r;
  assign bmin_out = bmin_r;
  assign bmax_out = bmax_r;

  a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_in.valid |=> ##1 ctl_r.valid)
    else $error("request lost in cell");

  a_no_revive: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ctl_r.valid && !s1_ctl_r.in_view) |=> !ctl_r.in_view)
    else $error("culled request marked in view");

  a_zero_plane: assert property (@(posedge clk) disable iff (!rst_n)
    (plane_r == '0 && ctl_in.valid && ctl_in.in_view) |=> ##1 ctl_r.in_view)
    else $error("zero plane culled a box");

endmodule

// ===== hdl/aabb_frustum_cull_unit.sv =====
// An accepted request passes through six plane cells of two register stages each, and
// its result strobe rises on out_valid as it leaves the last cell.
// Throughput: one request per cycle; busy stays low, start may be high every cycle.
// The receiver cannot stall; each result is shown for one cycle on out_valid.
// Reset (rst_n low, synchronous): pipeline emptied, all six planes cleared to zero.
module aabb_frustum_cull_unit
  import afc_pkg::*;
#(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [PLANE_W-1:0]            cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [TAG_W-1:0]              in_leaf_tag,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_z,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_z,
  output logic                          out_valid,
  output logic [TAG_W-1:0]              out_result_tag,
  output logic                          out_in_frustum
);

  ctl_t                          ctl_c  [PLANE_COUNT+1];
  logic [TAG_W-1:0]              tag_c  [PLANE_COUNT+1];
  logic signed [COORD_WIDTH-1:0] bmin_c [PLANE_COUNT+1][AXES];
  logic signed [COORD_WIDTH-1:0] bmax_c [PLANE_COUNT+1][AXES];

  assign busy = 1'b0;

  assign ctl_c[0].valid   = start && !busy;
  assign ctl_c[0].in_view = 1'b1;
  assign tag_c[0]         = in_leaf_tag;
  assign bmin_c[0][0]     = in_box_min_x;
  assign bmin_c[0][1]     = in_box_min_y;
  assign bmin_c[0][2]     = in_box_min_z;
  assign bmax_c[0][0]     = in_box_max_x;
  assign bmax_c[0][1]     = in_box_max_y;
  assign bmax_c[0][2]     = in_box_max_z;

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
    afc_cell #(
      .COORD_WIDTH      (COORD_WIDTH),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
      .PLANE_IDX        (plane_idx_t'(i))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg_we    (cfg_we),
      .cfg_index (cfg_index),
      .cfg_wdata (cfg_wdata),
      .ctl_in    (ctl_c[i]),
      .tag_in    (tag_c[i]),
      .bmin_in   (bmin_c[i]),
      .bmax_in   (bmax_c[i]),
      .ctl_out   (ctl_c[i+1]),
      .tag_out   (tag_c[i+1]),
      .bmin_out  (bmin_c[i+1]),
      .bmax_out  (bmax_c[i+1])
    );
  end

  assign out_valid      = ctl_c[PLANE_COUNT].valid;
  assign out_result_tag = tag_c[PLANE_COUNT];
  assign out_in_frustum = ctl_c[PLANE_COUNT].in_view;

endmodule
